// ===== src/random_pad_input_generator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the random pad input generator
// Short forms for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef RANDOM_PAD_INPUT_GENERATOR_TOP_ASSERT_SVH
`define RANDOM_PAD_INPUT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication
`define RPIG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RPIG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rpig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpig_pkg
// Types, constants and the xorshift32 step shared by the pad generator files.
// ----------------------------------------------------------------------------
package rpig_pkg;

    // xorshift32 shift amounts
    localparam int unsigned XS_SHL_A = 13;
    localparam int unsigned XS_SHR   = 17;
    localparam int unsigned XS_SHL_B = 5;

    // Register reset values
    localparam logic [31:0] SEED_RESET   = 32'd22;
    localparam logic [15:0] WINDOW_RESET = 16'd100;
    localparam logic [15:0] RANDOM_RESET = 16'd5;
    localparam logic [31:0] A_THR_RESET  = 32'd2147483647;
    localparam logic [31:0] B_THR_RESET  = 32'd2147483647;
    localparam logic [31:0] Z_THR_RESET  = 32'd858993459;

    // Stick value: (word mod 161) - 80
    localparam logic [8:0]  STICK_MOD   = 9'd161;
    localparam logic [7:0]  STICK_OFS   = 8'd80;
    // floor(2^39 / 161); quotient estimate is exact or one low for 32-bit words
    localparam logic [31:0] RECIP_161   = 32'd3414632384;
    localparam int unsigned RECIP_SHIFT = 39;

    // Button bits set by a random frame
    localparam logic [15:0] BTN_A_MASK = 16'h8000;
    localparam logic [15:0] BTN_B_MASK = 16'h4000;
    localparam logic [15:0] BTN_Z_MASK = 16'h2000;

    // Command codes
    localparam logic CMD_PAD = 1'b0;
    localparam logic CMD_MIX = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED   = 3'd0,
        CFG_WINDOW = 3'd1,
        CFG_RANDOM = 3'd2,
        CFG_A_THR  = 3'd3,
        CFG_B_THR  = 3'd4,
        CFG_Z_THR  = 3'd5
    } cfg_index_t;

    // Generator control from the sequencer
    typedef struct packed {
        logic load;   // load seed from configuration
        logic step;   // advance the generator
        logic mix;    // fold the mix word into the stepped value
    } rng_ctrl_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << XS_SHL_A);
        t = t ^ (t >> XS_SHR);
        t = t ^ (t << XS_SHL_B);
        return t;
    endfunction

endpackage

// ===== src/rpig_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpig_rng
// xorshift32 generator with seed load and mix, one step per cycle while ctrl.step is set.
// ----------------------------------------------------------------------------
module rpig_rng
    import rpig_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rng_ctrl_t   ctrl,
    input  logic [31:0] load_value,
    input  logic [31:0] mix_word,
    output logic [31:0] word
);

    logic [31:0] seed_reg;
    logic [31:0] seed_next;

    // Word that the next step produces
    assign word = xorshift32(seed_reg);

    // Select load, step or step-and-mix
    always_comb begin
        seed_next = seed_reg;
        if (ctrl.load) begin
            seed_next = load_value;
        end else if (ctrl.step) begin
            seed_next = ctrl.mix ? (word ^ mix_word) : word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= SEED_RESET;
        end else begin
            seed_reg <= seed_next;
        end
    end

endmodule

// ===== src/random_pad_input_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_pad_input_generator_top
// Per-frame choice between the real pad and random pad input.
// ----------------------------------------------------------------------------
// One item is processed at a time; s_tready is high only while the sequencer
// idles. A mix command passes through S_MIX1 and S_MIX2 before the next item
// can be taken. A frame goes through S_DRAW, S_MUL and S_CMP, a random frame
// then through S_BTN and the stick states, before its result enters the
// output register; S_OUT waits while that register is full and m_tready is
// low. The generator takes one xorshift32 step per cycle in the states that
// draw or mix (up to six draws per frame), and a single 32x32 multiplier,
// registered, serves the frame decision and the two mod-161 stick reductions.
// ----------------------------------------------------------------------------
module random_pad_input_generator_top
    import rpig_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] pad_buttons, [23:16] pad_stick_x, [31:24] pad_stick_y,
    // [63:32] mix_word
    input  logic [63:0]          s_tdata,
    // [0] cmd
    input  logic                 s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] out_buttons, [23:16] out_stick_x, [31:24] out_stick_y
    output logic [31:0]          m_tdata,
    // [0] passed_through
    output logic                 m_tuser,
    // Configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_DRAW,
        S_MUL,
        S_CMP,
        S_BTN,
        S_SDRAW,
        S_SMUL,
        S_SREM,
        S_SFIN,
        S_OUT
    } state_t;

    // Control state
    state_t                  state_reg, state_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [COUNT_BITS-1:0]   window_left_reg, window_left_next;
    logic [COUNT_BITS-1:0]   random_left_reg, random_left_next;
    logic [15:0]             held_reg, held_next;
    logic [1:0]              btn_idx_reg, btn_idx_next;
    logic                    stick_sel_reg, stick_sel_next;
    logic [15:0]             window_len_reg;
    logic [15:0]             random_cnt_reg;
    logic [31:0]             a_thr_reg, b_thr_reg, z_thr_reg;

    // Payload
    logic [15:0]             pad_btn_reg;
    logic [7:0]              pad_x_reg, pad_y_reg;
    logic [31:0]             mix_reg;
    logic [31:0]             word_reg, word_next;
    logic [63:0]             prod_reg;
    logic [63:0]             rhs_reg, rhs_next;
    logic [8:0]              rem_reg, rem_next;
    logic [7:0]              sx_reg, sx_next, sy_reg, sy_next;
    logic                    pass_reg, pass_next;
    logic [31:0]             m_data_reg;
    logic                    m_user_reg;

    // Shared datapath
    rng_ctrl_t               rng_ctrl;
    logic [31:0]             rng_word;
    logic [31:0]             mul_a, mul_b;
    logic [8:0]              quot;
    logic [8:0]              rem_fix;
    logic [31:0]             thr_sel;
    logic [15:0]             btn_mask;
    logic                    accept;
    logic                    out_load;
    logic                    seed_write;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser    = m_user_reg;
    assign seed_write = cfg_we && (cfg_index == CFG_SEED);
    assign out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    rpig_rng u_rng (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (rng_ctrl),
        .load_value (cfg_wdata),
        .mix_word   (mix_reg),
        .word       (rng_word)
    );

    // Step the generator in every state that draws a word and in both mix states
    always_comb begin
        rng_ctrl.load = seed_write;
        rng_ctrl.step = (state_reg == S_MIX1) || (state_reg == S_MIX2) ||
                        (state_reg == S_DRAW) || (state_reg == S_BTN)  ||
                        (state_reg == S_SDRAW);
        rng_ctrl.mix  = (state_reg == S_MIX1);
    end

    // Multiplier operands: frame decision or stick reciprocal
    always_comb begin
        mul_a = word_reg;
        mul_b = (state_reg == S_SMUL) ? RECIP_161 : 32'(window_left_reg);
    end

    // Threshold and button for the current button draw
    always_comb begin
        case (btn_idx_reg)
            2'd0:    begin thr_sel = a_thr_reg; btn_mask = BTN_A_MASK; end
            2'd1:    begin thr_sel = b_thr_reg; btn_mask = BTN_B_MASK; end
            default: begin thr_sel = z_thr_reg; btn_mask = BTN_Z_MASK; end
        endcase
    end

    // Remainder estimate and its correction
    assign quot    = prod_reg[RECIP_SHIFT+8:RECIP_SHIFT];
    assign rem_fix = (rem_reg >= STICK_MOD) ? (rem_reg - STICK_MOD) : rem_reg;

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        window_left_next = window_left_reg;
        random_left_next = random_left_reg;
        held_next        = held_reg;
        btn_idx_next     = btn_idx_reg;
        stick_sel_next   = stick_sel_reg;
        word_next        = word_reg;
        rhs_next         = rhs_reg;
        rem_next         = rem_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        pass_next        = pass_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_MIX) begin
                        state_next = S_MIX1;
                    end else begin
                        // Start a new window when the old one ran out
                        if (window_left_reg == '0) begin
                            window_left_next = COUNT_BITS'(window_len_reg);
                            random_left_next = COUNT_BITS'(random_cnt_reg);
                        end
                        state_next = S_DRAW;
                    end
                end
            end
            S_MIX1: state_next = S_MIX2;
            S_MIX2: state_next = S_IDLE;
            S_DRAW: begin
                word_next  = rng_word;
                state_next = S_MUL;
            end
            S_MUL: begin
                // random_left * 0xFFFFFFFF
                rhs_next   = {32'(random_left_reg), 32'd0} - 64'(random_left_reg);
                state_next = S_CMP;
            end
            S_CMP: begin
                window_left_next = window_left_reg - 1'b1;
                if (prod_reg < rhs_reg) begin
                    random_left_next = random_left_reg - 1'b1;
                    btn_idx_next     = 2'd0;
                    pass_next        = 1'b0;
                    state_next       = S_BTN;
                end else begin
                    held_next  = pad_btn_reg;
                    sx_next    = pad_x_reg;
                    sy_next    = pad_y_reg;
                    pass_next  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_BTN: begin
                if (rng_word < thr_sel) begin
                    held_next = held_reg | btn_mask;
                end
                btn_idx_next = btn_idx_reg + 1'b1;
                if (btn_idx_reg == 2'd2) begin
                    stick_sel_next = 1'b0;
                    state_next     = S_SDRAW;
                end
            end
            S_SDRAW: begin
                word_next  = rng_word;
                state_next = S_SMUL;
            end
            S_SMUL: state_next = S_SREM;
            S_SREM: begin
                // Low bits suffice: the remainder estimate is below 322
                rem_next   = word_reg[8:0] - 9'(quot * STICK_MOD);
                state_next = S_SFIN;
            end
            S_SFIN: begin
                if (!stick_sel_reg) begin
                    sx_next        = rem_fix[7:0] - STICK_OFS;
                    stick_sel_next = 1'b1;
                    state_next     = S_SDRAW;
                end else begin
                    sy_next    = rem_fix[7:0] - STICK_OFS;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Seed write restarts the sampling window
        if (seed_write) begin
            window_left_next = '0;
            random_left_next = '0;
        end
    end

    // Output valid: set on load, drop after the transfer
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // State, counters, output valid and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid_reg    <= 1'b0;
            window_left_reg <= '0;
            random_left_reg <= '0;
            held_reg        <= '0;
            btn_idx_reg     <= 2'd0;
            stick_sel_reg   <= 1'b0;
            window_len_reg  <= WINDOW_RESET;
            random_cnt_reg  <= RANDOM_RESET;
            a_thr_reg       <= A_THR_RESET;
            b_thr_reg       <= B_THR_RESET;
            z_thr_reg       <= Z_THR_RESET;
        end else begin
            state_reg       <= state_next;
            m_tvalid_reg    <= m_tvalid_next;
            window_left_reg <= window_left_next;
            random_left_reg <= random_left_next;
            held_reg        <= held_next;
            btn_idx_reg     <= btn_idx_next;
            stick_sel_reg   <= stick_sel_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SEED:   ;
                    CFG_WINDOW: window_len_reg <= cfg_wdata[15:0];
                    CFG_RANDOM: random_cnt_reg <= cfg_wdata[15:0];
                    CFG_A_THR:  a_thr_reg      <= cfg_wdata;
                    CFG_B_THR:  b_thr_reg      <= cfg_wdata;
                    CFG_Z_THR:  z_thr_reg      <= cfg_wdata;
                    default:    ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            pad_btn_reg <= s_tdata[15:0];
            pad_x_reg   <= s_tdata[23:16];
            pad_y_reg   <= s_tdata[31:24];
            mix_reg     <= s_tdata[63:32];
        end
        word_reg <= word_next;
        prod_reg <= mul_a * mul_b;
        rhs_reg  <= rhs_next;
        rem_reg  <= rem_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        pass_reg <= pass_next;
        if (out_load) begin
            m_data_reg <= {sy_reg, sx_reg, held_reg};
            m_user_reg <= pass_reg;
        end
    end

endmodule

// ===== src/rpig_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpig_checker
// Port-level checks on the random pad input generator, bound to the top.
// ----------------------------------------------------------------------------
`include "random_pad_input_generator_top_assert.svh"

module rpig_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [31:0]          m_tdata,
    input logic                 m_tuser
);

    // Hold a stalled result
    `RPIG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Block is busy right after taking an item
    `RPIG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after an input transfer")

    // A new result never appears in the cycle after an input transfer
    `RPIG_ASSERT_NOW(a_no_instant_result, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result too soon after input")

    // Random sticks stay within -80..80
    `RPIG_ASSERT_NOW(a_stick_range, m_tvalid && !m_tuser, (m_tdata[23:16] <= 8'd80 || m_tdata[23:16] >= 8'd176) && (m_tdata[31:24] <= 8'd80 || m_tdata[31:24] >= 8'd176), "random stick out of range")

endmodule

bind random_pad_input_generator_top rpig_checker u_rpig_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - random pad input generator testbench
// Streams pad frames and seed-mix commands into the generator and checks
// every result against a cycle-free model of the xorshift selection sampler.
// Directed settings cover the zero seed, a zero window, more random frames
// than the window holds, threshold extremes and ignored register indexes.
// Random phases follow with fresh settings, random idling on both sides and
// long receiver hold-offs that back the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    import rpig_pkg::*;

    localparam int CNT_W         = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 48;

    // Register indexes the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic        cmd;
        logic [15:0] buttons;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [31:0] mix;
    } pad_item_t;

    typedef struct packed {
        logic [15:0] buttons;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic        passed;
    } pad_res_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;
    logic                 s_tuser   = CMD_PAD;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SEED;
    logic [31:0]          cfg_wdata = '0;

    random_pad_input_generator_top #(
        .COUNT_BITS (CNT_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Generator model: register copies and sampler state
    logic [31:0]      cfg_seed, cfg_a, cfg_b, cfg_z;
    logic [15:0]      cfg_window, cfg_random;
    logic [31:0]      gen_seed;
    logic [CNT_W-1:0] win_left, rnd_left;
    logic [15:0]      held;

    pad_item_t pad_in_q[$];
    pad_res_t  pad_out_q[$];

    int err_cnt    = 0;
    int n_results  = 0;
    int n_random   = 0;
    int n_passed   = 0;
    int n_mix      = 0;
    int n_settings = 1;

    // Reset values of registers and state
    task automatic model_reset();
        cfg_seed   = SEED_RESET;
        cfg_window = WINDOW_RESET;
        cfg_random = RANDOM_RESET;
        cfg_a      = A_THR_RESET;
        cfg_b      = B_THR_RESET;
        cfg_z      = Z_THR_RESET;
        gen_seed   = SEED_RESET;
        win_left   = '0;
        rnd_left   = '0;
        held       = '0;
    endtask

    // Advance the xorshift generator and return the new word
    function automatic logic [31:0] next_word();
        logic [31:0] x;
        x = gen_seed;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        gen_seed = x;
        return x;
    endfunction

    // Stick byte: word mod 161, shifted down by 80
    function automatic logic [7:0] next_stick();
        logic [31:0] v;
        v = next_word() % 32'd161;
        return v[7:0] - STICK_OFS;
    endfunction

    // Apply one accepted item to the model and queue its result, if any
    task automatic apply_item(input pad_item_t it);
        pad_res_t    r;
        logic [31:0] w;
        logic [63:0] lhs, rhs;
        if (it.cmd == CMD_MIX) begin
            gen_seed = next_word() ^ it.mix;
            gen_seed = next_word();
            n_mix++;
            return;
        end
        if (win_left == '0) begin
            win_left = cfg_window[CNT_W-1:0];
            rnd_left = cfg_random[CNT_W-1:0];
        end
        w   = next_word();
        lhs = {32'd0, w} * 64'(win_left);
        rhs = 64'(rnd_left) * 64'h0000_0000_FFFF_FFFF;
        win_left = win_left - 1'b1;
        if (lhs < rhs) begin
            rnd_left = rnd_left - 1'b1;
            if (next_word() < cfg_a) held = held | BTN_A_MASK;
            if (next_word() < cfg_b) held = held | BTN_B_MASK;
            if (next_word() < cfg_z) held = held | BTN_Z_MASK;
            r.buttons = held;
            r.stick_x = next_stick();
            r.stick_y = next_stick();
            r.passed  = 1'b0;
        end else begin
            held      = it.buttons;
            r.buttons = it.buttons;
            r.stick_x = it.stick_x;
            r.stick_y = it.stick_y;
            r.passed  = 1'b1;
        end
        pad_out_q.push_back(r);
    endtask

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= 20) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic pad_item_t mk(input logic cmd, input logic [15:0] b,
                                     input logic [7:0] x, input logic [7:0] y,
                                     input logic [31:0] m);
        pad_item_t it;
        it.cmd     = cmd;
        it.buttons = b;
        it.stick_x = x;
        it.stick_y = y;
        it.mix     = m;
        return it;
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one item at a time from pad_in_q, random gaps
    // ------------------------------------------------------------------
    pad_item_t tx_cur;
    bit        tx_busy  = 1'b0;
    bit        tx_burst = 1'b0;
    int        tx_wait  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_busy  = 1'b0;
            tx_wait  = 0;
        end else begin
            // Retire the accepted transfer
            if (tx_busy && s_tready) begin
                apply_item(tx_cur);
                tx_busy = 1'b0;
            end
            // Launch the next item once its gap has run out
            if (!tx_busy) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (pad_in_q.size() != 0) begin
                    tx_cur  = pad_in_q.pop_front();
                    tx_busy = 1'b1;
                    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
                    tx_wait = draw_gap(tx_burst);
                    s_tdata <= {tx_cur.mix, tx_cur.stick_y, tx_cur.stick_x,
                                tx_cur.buttons};
                    s_tuser <= tx_cur.cmd;
                end
            end
            s_tvalid <= tx_busy;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each transfer, stall at random
    // ------------------------------------------------------------------
    pad_res_t got, want;
    bit       rx_burst  = 1'b0;
    bit       rx_rdy;
    int       rx_wait   = 0;
    int       hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tdata[23:16], m_tdata[31:24], m_tuser};
                if (pad_out_q.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing expected",
                                     n_results));
                end else begin
                    want = pad_out_q.pop_front();
                    if (want.passed) n_passed++;
                    else n_random++;
                    if (got.buttons !== want.buttons)
                        report($sformatf("result %0d: buttons %h, expected %h",
                                         n_results, got.buttons, want.buttons));
                    if (got.stick_x !== want.stick_x)
                        report($sformatf("result %0d: stick x %h, expected %h",
                                         n_results, got.stick_x, want.stick_x));
                    if (got.stick_y !== want.stick_y)
                        report($sformatf("result %0d: stick y %h, expected %h",
                                         n_results, got.stick_y, want.stick_y));
                    if (got.passed !== want.passed)
                        report($sformatf("result %0d: pass-through %b, expected %b",
                                         n_results, got.passed, want.passed));
                end
                n_results++;
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_wait = draw_gap(rx_burst);
                // Hold off now and then so the block backs up into its input
                if (n_results % 128 == 60) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_rdy = 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                rx_rdy = 1'b0;
            end else begin
                rx_rdy = 1'b1;
            end
            m_tready <= rx_rdy;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------

    // Write one register at the next edge and mirror it in the model
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SEED: begin
                cfg_seed = val;
                gen_seed = val;
                win_left = '0;
                rnd_left = '0;
            end
            CFG_WINDOW: cfg_window = val[15:0];
            CFG_RANDOM: cfg_random = val[15:0];
            CFG_A_THR:  cfg_a = val;
            CFG_B_THR:  cfg_b = val;
            CFG_Z_THR:  cfg_z = val;
            default: ;
        endcase
    endtask

    // Wait until every item is in and every result is out, then let mixes finish
    task automatic settle();
        while (pad_in_q.size() != 0 || tx_busy || pad_out_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_thr();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Draw a fresh setting, extremes weighted in
    task automatic shuffle_config();
        logic [15:0] win, rnd;
        logic [31:0] seed;
        case ($urandom_range(0, 5))
            0:       win = 16'd1;
            1:       win = 16'hFFFF;
            2:       win = 16'd0;
            default: win = 16'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 5))
            0:       rnd = 16'd0;
            1:       rnd = win;
            2:       rnd = 16'hFFFF;
            3:       rnd = win + 16'($urandom_range(1, 4));
            default: rnd = 16'($urandom_range(0, win));
        endcase
        case ($urandom_range(0, 7))
            0:       seed = 32'h0000_0000;
            1:       seed = 32'hFFFF_FFFF;
            default: seed = $urandom();
        endcase
        if ($urandom_range(0, 1) == 0) set_reg(CFG_SEED, seed);
        // Upper bits of the 16-bit registers carry noise
        set_reg(CFG_WINDOW, {16'($urandom()), win});
        set_reg(CFG_RANDOM, {16'($urandom()), rnd});
        if ($urandom_range(0, 2) != 0) set_reg(CFG_A_THR, pick_thr());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_B_THR, pick_thr());
        if ($urandom_range(0, 2) != 0) set_reg(CFG_Z_THR, pick_thr());
        if ($urandom_range(0, 3) == 0)
            set_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_6 : CFG_SPARE_7, $urandom());
        n_settings++;
    endtask

    initial begin
        pad_item_t it;
        model_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // Reset settings: field extremes, unused fields, mixes
        pad_in_q.push_back(mk(CMD_PAD, 16'h0000, 8'h00, 8'h00, 32'h0000_0000));
        pad_in_q.push_back(mk(CMD_PAD, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
        pad_in_q.push_back(mk(CMD_PAD, 16'hA5A5, 8'h80, 8'h7F, 32'h5A5A_5A5A));
        pad_in_q.push_back(mk(CMD_MIX, 16'hFFFF, 8'hFF, 8'hFF, 32'h0000_0000));
        pad_in_q.push_back(mk(CMD_PAD, 16'h5A5A, 8'h01, 8'hFE, 32'hDEAD_BEEF));
        pad_in_q.push_back(mk(CMD_MIX, 16'h0000, 8'h00, 8'h00, 32'hFFFF_FFFF));
        pad_in_q.push_back(mk(CMD_PAD, 16'h1FFF, 8'h7F, 8'h80, 32'h0000_0000));
        pad_in_q.push_back(mk(CMD_PAD, 16'hE000, 8'h00, 8'hFF, 32'h1234_5678));
        settle();

        // Zero seed: generator stuck at zero until a mix
        set_reg(CFG_SEED,   32'h0000_0000);
        set_reg(CFG_WINDOW, 32'hFFFF_0004);
        set_reg(CFG_RANDOM, 32'h0000_0002);
        set_reg(CFG_A_THR,  32'hFFFF_FFFF);
        set_reg(CFG_B_THR,  32'h0000_0000);
        set_reg(CFG_Z_THR,  32'hFFFF_FFFF);
        n_settings++;
        repeat (5) pad_in_q.push_back(mk(CMD_PAD, 16'h0F0F, 8'h10, 8'hF0, 32'h0));
        pad_in_q.push_back(mk(CMD_MIX, 16'h0000, 8'h00, 8'h00, 32'h0000_0001));
        repeat (2) pad_in_q.push_back(mk(CMD_PAD, 16'h0101, 8'h22, 8'hDD, 32'h0));
        settle();

        // Zero window length: reload as zero, then wrap to all ones
        set_reg(CFG_SEED,   32'h0000_0001);
        set_reg(CFG_WINDOW, 32'h0000_0000);
        set_reg(CFG_RANDOM, 32'h0000_0003);
        n_settings++;
        repeat (4) pad_in_q.push_back(mk(CMD_PAD, 16'h00FF, 8'h33, 8'hCC, 32'h0));
        settle();

        // More random frames than the window holds; ignored indexes
        set_reg(CFG_SEED,    32'hFFFF_FFFF);
        set_reg(CFG_WINDOW,  32'h0000_0003);
        set_reg(CFG_RANDOM,  32'h0000_0009);
        set_reg(CFG_A_THR,   32'h0000_0000);
        set_reg(CFG_B_THR,   32'hFFFF_FFFF);
        set_reg(CFG_Z_THR,   32'h0000_0000);
        set_reg(CFG_SPARE_7, 32'hFFFF_FFFF);
        set_reg(CFG_SPARE_6, 32'h0000_0000);
        n_settings++;
        repeat (5) pad_in_q.push_back(mk(CMD_PAD, 16'hFF00, 8'h44, 8'hBB, 32'h0));
        settle();

        // Random phases under fresh settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            shuffle_config();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it.cmd     = ($urandom_range(0, 6) == 0) ? CMD_MIX : CMD_PAD;
                it.buttons = 16'($urandom());
                it.stick_x = 8'($urandom());
                it.stick_y = 8'($urandom());
                it.mix     = $urandom();
                pad_in_q.push_back(it);
            end
            settle();
        end

        $display("Covered %0d frames (%0d random, %0d pass-through) and %0d mixes",
                 n_results, n_random, n_passed, n_mix);
        $display("across %0d register settings; %0d mismatches", n_settings, err_cnt);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
